>>> hw/rtl/pef_pkg.sv
// Package for the prime exponent factorizer: sizes, microcode format and microprogram.
package pef_pkg;

    // Number of low input bits that take part in the factorization.
    localparam int VALUE_BITS = 8;
    // Fixed widths of the channel fields.
    localparam int VALUE_W = 8;
    localparam int EXP_W   = 3;
    // Width of the microcode address.
    localparam int ADDR_W  = 5;

    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [ADDR_W-1:0]     t_addr;

    // Datapath action of one microcode step.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_NP,
        OP_DIV_CD,
        OP_TAKE_Q,
        OP_EMIT,
        OP_EMIT_SMALL,
        OP_NEXTC,
        OP_SET_D2,
        OP_INC_C,
        OP_INC_D,
        OP_SET_P
    } t_op;

    // Jump condition of one microcode step; the step falls through when it is false.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_N_LE1,
        C_N_EQ1,
        C_DIV_BUSY,
        C_REM_NZ,
        C_OUT_FULL
    } t_cond;

    // One control word.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_addr target;
    } t_uword;

    // Status flags that the datapath returns to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic n_le1;
        logic n_eq1;
        logic div_busy;
        logic rem_nz;
        logic dsq_gt_c;
        logic out_full;
    } t_status;

    // Microprogram addresses.
    localparam t_addr A_WAIT      = t_addr'(0);
    localparam t_addr A_CHECK     = t_addr'(1);
    localparam t_addr A_DIV_N     = t_addr'(2);
    localparam t_addr A_WAIT_N    = t_addr'(3);
    localparam t_addr A_TEST_N    = t_addr'(4);
    localparam t_addr A_TAKE_Q    = t_addr'(5);
    localparam t_addr A_EMIT      = t_addr'(6);
    localparam t_addr A_NEXTC     = t_addr'(7);
    localparam t_addr A_SET_D     = t_addr'(8);
    localparam t_addr A_TEST_SQ   = t_addr'(9);
    localparam t_addr A_DIV_C     = t_addr'(10);
    localparam t_addr A_WAIT_C    = t_addr'(11);
    localparam t_addr A_TEST_C    = t_addr'(12);
    localparam t_addr A_INC_C     = t_addr'(13);
    localparam t_addr A_SET_P     = t_addr'(14);
    localparam t_addr A_INC_D     = t_addr'(15);
    localparam t_addr A_SMALL     = t_addr'(16);
    localparam t_addr A_SMALL_END = t_addr'(17);

    // Extra jump condition for the square test, kept outside the three-bit field
    // by placing it on its own step: the square test step uses C_NEVER and is
    // decoded by address in the sequencer.

    // Microprogram ROM.
    function automatic t_uword ucode_rom(t_addr a);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: A_WAIT};
        unique case (a)
            A_WAIT:      w = '{op: OP_LOAD,       cond: C_NO_IN,    target: A_WAIT};
            A_CHECK:     w = '{op: OP_NOP,        cond: C_N_LE1,    target: A_SMALL};
            A_DIV_N:     w = '{op: OP_DIV_NP,     cond: C_NEVER,    target: A_WAIT};
            A_WAIT_N:    w = '{op: OP_NOP,        cond: C_DIV_BUSY, target: A_WAIT_N};
            A_TEST_N:    w = '{op: OP_NOP,        cond: C_REM_NZ,   target: A_EMIT};
            A_TAKE_Q:    w = '{op: OP_TAKE_Q,     cond: C_ALWAYS,   target: A_DIV_N};
            A_EMIT:      w = '{op: OP_EMIT,       cond: C_OUT_FULL, target: A_EMIT};
            A_NEXTC:     w = '{op: OP_NEXTC,      cond: C_N_EQ1,    target: A_WAIT};
            A_SET_D:     w = '{op: OP_SET_D2,     cond: C_NEVER,    target: A_WAIT};
            A_TEST_SQ:   w = '{op: OP_NOP,        cond: C_NEVER,    target: A_SET_P};
            A_DIV_C:     w = '{op: OP_DIV_CD,     cond: C_NEVER,    target: A_WAIT};
            A_WAIT_C:    w = '{op: OP_NOP,        cond: C_DIV_BUSY, target: A_WAIT_C};
            A_TEST_C:    w = '{op: OP_NOP,        cond: C_REM_NZ,   target: A_INC_D};
            A_INC_C:     w = '{op: OP_INC_C,      cond: C_ALWAYS,   target: A_SET_D};
            A_SET_P:     w = '{op: OP_SET_P,      cond: C_ALWAYS,   target: A_DIV_N};
            A_INC_D:     w = '{op: OP_INC_D,      cond: C_ALWAYS,   target: A_TEST_SQ};
            A_SMALL:     w = '{op: OP_EMIT_SMALL, cond: C_OUT_FULL, target: A_SMALL};
            A_SMALL_END: w = '{op: OP_NOP,        cond: C_ALWAYS,   target: A_WAIT};
            default:     w = '{op: OP_NOP,        cond: C_ALWAYS,   target: A_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/pef_in_if.sv
// Input channel of the prime exponent factorizer.
interface pef_in_if import pef_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> hw/rtl/pef_out_if.sv
// Result channel of the prime exponent factorizer.
interface pef_out_if import pef_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] prime;
    logic [EXP_W-1:0]   exponent;
    logic               last;
    logic               empty_res;

    modport source (output valid, output prime, output exponent, output last,
                    output empty_res, input ready);
    modport sink   (input valid, input prime, input exponent, input last,
                    input empty_res, output ready);
endinterface

>>> hw/rtl/pef_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module pef_divider import pef_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_val i_dividend,
    input  t_val i_divisor,
    output logic o_busy,
    output t_val o_quot,
    output t_val o_rem
);

    localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    t_val             r_quot;
    t_val             r_rem;
    t_val             r_div;

    logic [VALUE_BITS:0] trial;
    logic [VALUE_BITS:0] diff;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        trial = {r_rem, r_quot[VALUE_BITS-1]};
        diff  = trial - {1'b0, r_div};
    end

    // Control: busy after a start until the bit counter has counted down through every dividend bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(VALUE_BITS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: the quotient register doubles as the dividend shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (!diff[VALUE_BITS]) begin
                r_rem  <= diff[VALUE_BITS-1:0];
                r_quot <= {r_quot[VALUE_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= trial[VALUE_BITS-1:0];
                r_quot <= {r_quot[VALUE_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

>>> hw/rtl/pef_sequencer.sv
// Microcode sequencer: step counter, control ROM and jump logic.
module pef_sequencer import pef_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_uword  o_uword
);

    t_addr  r_pc;
    t_addr  n_pc;
    t_uword uword;
    logic   take;

    // Fetch the control word and decide whether its jump is taken.
    always_comb begin
        uword = ucode_rom(r_pc);
        unique case (uword.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !i_status.in_valid;
            C_N_LE1:    take = i_status.n_le1;
            C_N_EQ1:    take = i_status.n_eq1;
            C_DIV_BUSY: take = i_status.div_busy;
            C_REM_NZ:   take = i_status.rem_nz;
            C_OUT_FULL: take = i_status.out_full;
            default:    take = 1'b0;
        endcase
        // The square test step jumps when the divisor squared exceeds the candidate.
        if (r_pc == A_TEST_SQ) begin
            take = i_status.dsq_gt_c;
        end
        n_pc = take ? uword.target : r_pc + 1'b1;
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uword;

endmodule

>>> hw/rtl/pef_datapath.sv
// Datapath: value, prime, exponent, candidate and divisor registers, divider, result register.
module pef_datapath import pef_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_uword    i_uword,
    output t_status   o_status,
    pef_in_if.sink    i_in,
    pef_out_if.source o_out
);

    t_val             r_n;
    t_val             r_p;
    t_val             r_c;
    t_val             r_d;
    logic [EXP_W-1:0] r_e;

    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_prime;
    logic [EXP_W-1:0]   r_out_exp;
    logic               r_out_last;
    logic               r_out_empty;

    logic                    div_start;
    t_val                    div_a;
    t_val                    div_b;
    logic                    div_busy;
    t_val                    div_q;
    t_val                    div_r;
    logic [2*VALUE_BITS-1:0] d_sq;
    logic                    out_full;
    logic                    emit;
    logic                    accept;

    // Operand selection for the shared divider.
    always_comb begin
        div_start = (i_uword.op == OP_DIV_NP) || (i_uword.op == OP_DIV_CD);
        div_a     = (i_uword.op == OP_DIV_CD) ? r_c : r_n;
        div_b     = (i_uword.op == OP_DIV_CD) ? r_d : r_p;
    end

    pef_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // Status back to the sequencer.
    always_comb begin
        d_sq     = r_d * r_d;
        out_full = r_out_valid && !o_out.ready;
        emit     = ((i_uword.op == OP_EMIT) || (i_uword.op == OP_EMIT_SMALL)) && !out_full;
        accept   = (i_uword.op == OP_LOAD) && i_in.valid;
        o_status = '{
            in_valid: i_in.valid,
            n_le1:    (r_n <= t_val'(1)),
            n_eq1:    (r_n == t_val'(1)),
            div_busy: div_busy,
            rem_nz:   (div_r != '0),
            dsq_gt_c: (d_sq > {{VALUE_BITS{1'b0}}, r_c}),
            out_full: out_full
        };
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        unique case (i_uword.op)
            OP_LOAD: begin
                if (accept) begin
                    r_n <= i_in.value[VALUE_BITS-1:0];
                    r_p <= t_val'(2);
                    r_e <= '0;
                end
            end
            OP_TAKE_Q: begin
                r_n <= div_q;
                r_e <= r_e + 1'b1;
            end
            OP_NEXTC: begin
                r_c <= r_p + 1'b1;
                r_e <= '0;
            end
            OP_SET_D2: r_d <= t_val'(2);
            OP_INC_C:  r_c <= r_c + 1'b1;
            OP_INC_D:  r_d <= r_d + 1'b1;
            OP_SET_P:  r_p <= r_c;
            default: begin
            end
        endcase
    end

    // Result register: loads on an emit step, empties on an output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (i_uword.op == OP_EMIT_SMALL) begin
                r_out_prime <= VALUE_W'(2);
                r_out_exp   <= '0;
                r_out_last  <= 1'b1;
                r_out_empty <= (r_n == '0);
            end else begin
                r_out_prime <= VALUE_W'(r_p);
                r_out_exp   <= r_e;
                r_out_last  <= (r_n == t_val'(1));
                r_out_empty <= 1'b0;
            end
        end
    end

    // No value is taken while reset is held.
    assign i_in.ready      = (i_uword.op == OP_LOAD) && i_rst_n;
    assign o_out.valid     = r_out_valid;
    assign o_out.prime     = r_out_prime;
    assign o_out.exponent  = r_out_exp;
    assign o_out.last      = r_out_last;
    assign o_out.empty_res = r_out_empty;

endmodule

>>> hw/rtl/prime_exponent_factorizer.sv
// Top level of the prime exponent factorizer.
//
// Each value transferred on i_in is factorized by trial division. The block
// returns on o_out one result per prime 2, 3, 5, ... up to the largest prime
// factor, each with its exponent; the final result of a run has last set.
// Values one and zero give a single result for prime 2 with exponent 0;
// for zero, empty_res is set.
// Values are taken one at a time: i_in.ready is high only while the
// sequencer waits for a new value, and a new value is taken once the last
// result of the previous run sits in the result register.
// Timing is set by the serial divider, which is started once per trial
// division: once per division of the value by a prime and once per divisor
// tried during the next-prime search. Among values above one, value two has
// the shortest run and value 251 the longest, since its search walks every
// candidate up to 251; values zero and one skip the divider. The first
// result, for prime 2, appears once the value has been divided by two until
// a remainder shows; for zero and one it appears without any division.
// When the receiver stalls, the result register holds its item and the
// sequencer waits on its emit step. Reset returns the sequencer to its wait
// step, empties the result register and holds i_in.ready low.
module prime_exponent_factorizer import pef_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pef_in_if.sink    i_in,
    pef_out_if.source o_out
);

    t_uword  uword;
    t_status status;

    pef_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uword  (uword)
    );

    pef_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_uword  (uword),
        .o_status (status),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule
